// ===== design/cfr_pkg.sv =====
package cfr_pkg;
    localparam int NumRegs = 6;
    localparam int RegW = 16;
    localparam int IdxW = 3;
    localparam int CosW = 16;
    localparam int OutW = 16;
    localparam int TW = 25;
    localparam int SW = 18;
    localparam int DW = 22;
    localparam int TSW = 27;
    localparam int NumW = 28;
    localparam int QW = 17;
    localparam int DivSteps = QW;
    localparam int NumChan = 3;

    typedef enum logic [IdxW-1:0] {
        REG_ETA_RED = 3'd0,
        REG_ETA_GREEN = 3'd1,
        REG_ETA_BLUE = 3'd2,
        REG_ABS_RED = 3'd3,
        REG_ABS_GREEN = 3'd4,
        REG_ABS_BLUE = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [NumW-1:0] num;
        logic [NumW-1:0] den;
    } frac_t;
endpackage

// ===== design/cfr_divider.sv =====
module cfr_divider (
    input  logic                 aclk,
    input  logic                 advance,
    input  cfr_pkg::frac_t       frac_in,
    output logic [cfr_pkg::QW-1:0] quot_out
);
    import cfr_pkg::*;

    // one quotient bit per stage, restoring division of num*65536 by den
    logic [NumW-1:0] rem_reg [1:DivSteps];
    logic [NumW-1:0] den_reg [1:DivSteps];
    logic [QW-1:0]   q_reg   [1:DivSteps];
    logic            zero_reg [1:DivSteps];

    for (genvar i = 0; i < DivSteps; i++) begin : g_step
        logic [NumW:0]   trial;
        logic            fits;
        logic [NumW-1:0] den_cur;
        logic [QW-1:0]   q_cur;
        logic            zero_cur;
        if (i == 0) begin : g_first
            // first step compares num against den (quotient bit 16 is num>=den)
            assign trial = {1'b0, frac_in.num};
            assign den_cur = frac_in.den;
            assign q_cur = '0;
            assign zero_cur = (frac_in.den == '0);
        end else begin : g_next
            assign trial = {rem_reg[i], 1'b0};
            assign den_cur = den_reg[i];
            assign q_cur = q_reg[i];
            assign zero_cur = zero_reg[i];
        end
        assign fits = (trial >= {1'b0, den_cur});
        always_ff @(posedge aclk) begin
            if (advance) begin
                rem_reg[i+1]  <= fits ? NumW'(trial - {1'b0, den_cur}) : trial[NumW-1:0];
                den_reg[i+1]  <= den_cur;
                q_reg[i+1]    <= {q_cur[QW-2:0], fits};
                zero_reg[i+1] <= zero_cur;
            end
        end
    end

    assign quot_out = zero_reg[DivSteps] ? '0 : q_reg[DivSteps];
endmodule

// ===== design/cfr_front.sv =====
module cfr_front (
    input  logic                       aclk,
    input  logic                       advance,
    input  logic [cfr_pkg::RegW-1:0]   eta,
    input  logic [cfr_pkg::RegW-1:0]   absorb,
    input  logic [cfr_pkg::CosW-1:0]   cos_in,
    output cfr_pkg::frac_t             par_out,
    output cfr_pkg::frac_t             perp_out
);
    import cfr_pkg::*;

    logic [TW-1:0] t_reg;
    logic [SW-1:0] s_reg;
    logic [DW-1:0] d_reg, d2_reg;
    logic [TW-1:0] t2_reg;
    logic [SW-1:0] s2_reg;
    logic [TSW-1:0] ts_reg;
    logic [32:0]   sq_sum;
    logic [31:0]   cc, ec;
    logic [TW+SW-1:0] tsp;
    logic [NumW-1:0] pa, pb, qa;

    assign sq_sum = {1'b0, 32'(eta) * 32'(eta)} + {1'b0, 32'(absorb) * 32'(absorb)};
    assign cc = 32'(cos_in) * 32'(cos_in);
    assign ec = 32'(eta) * 32'(cos_in);
    assign tsp = (TW+SW)'(t_reg) * (TW+SW)'(s_reg);

    always_ff @(posedge aclk) begin
        if (advance) begin
            t_reg  <= sq_sum[32:8];
            s_reg  <= cc[31:14];
            d_reg  <= ec[31:10];
            ts_reg <= TSW'(tsp >> 16);
            t2_reg <= t_reg;
            s2_reg <= s_reg;
            d2_reg <= d_reg;
        end
    end

    assign pa = NumW'(ts_reg) + NumW'(65536);
    assign qa = NumW'(t2_reg) + NumW'(s2_reg);
    assign pb = NumW'(d2_reg);

    always_ff @(posedge aclk) begin
        if (advance) begin
            par_out.num  <= (pa > pb) ? pa - pb : '0;
            par_out.den  <= pa + pb;
            perp_out.num <= (qa > pb) ? qa - pb : '0;
            perp_out.den <= qa + pb;
        end
    end
endmodule

// ===== design/conductor_fresnel_reflectance_unit.sv =====
// channel | dir | signals
// s_      | in  | s_valid, s_ready, s_cos_incidence
// m_      | out | m_valid, m_ready, m_reflect_red/green/blue
// cfg     | in  | cfg_we, cfg_idx, cfg_data
// one item per cycle while the output register is not stalled (3 front stages, 17 divider stages, 1 out)
// the whole pipeline advances when the output register is empty or taken
// aresetn clears valid bits and resets the six index/absorption registers
module conductor_fresnel_reflectance_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [cfr_pkg::IdxW-1:0]   cfg_idx,
    input  logic [cfr_pkg::RegW-1:0]   cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [cfr_pkg::CosW-1:0]   s_cos_incidence,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [cfr_pkg::OutW-1:0]   m_reflect_red,
    output logic [cfr_pkg::OutW-1:0]   m_reflect_green,
    output logic [cfr_pkg::OutW-1:0]   m_reflect_blue
);
    import cfr_pkg::*;

    localparam int Lat = 3 + DivSteps;

    logic [RegW-1:0] eta_reg [NumChan];
    logic [RegW-1:0] abs_reg [NumChan];
    logic [Lat-1:0]  vld_reg;
    logic            advance;
    logic [OutW-1:0] res [NumChan];
    logic            out_vld_reg;
    logic [OutW-1:0] out_reg [NumChan];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumChan; i++) begin
                eta_reg[i] <= RegW'(4096);
                abs_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_ETA_RED:   eta_reg[0] <= cfg_data;
                REG_ETA_GREEN: eta_reg[1] <= cfg_data;
                REG_ETA_BLUE:  eta_reg[2] <= cfg_data;
                REG_ABS_RED:   abs_reg[0] <= cfg_data;
                REG_ABS_GREEN: abs_reg[1] <= cfg_data;
                REG_ABS_BLUE:  abs_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance = !out_vld_reg || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[Lat-2:0], s_valid};
        end
    end

    for (genvar ch = 0; ch < NumChan; ch++) begin : g_ch
        frac_t par, perp;
        logic [QW-1:0] qp, qs;
        logic [QW:0] sum;
        cfr_front u_front (
            .aclk(aclk), .advance(advance), .eta(eta_reg[ch]), .absorb(abs_reg[ch]),
            .cos_in(s_cos_incidence), .par_out(par), .perp_out(perp)
        );
        cfr_divider u_div_par (
            .aclk(aclk), .advance(advance), .frac_in(par), .quot_out(qp)
        );
        cfr_divider u_div_perp (
            .aclk(aclk), .advance(advance), .frac_in(perp), .quot_out(qs)
        );
        assign sum = {1'b0, qp} + {1'b0, qs};
        assign res[ch] = sum[QW] ? '1 : sum[OutW:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= vld_reg[Lat-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < NumChan; i++) out_reg[i] <= res[i];
        end
    end

    assign m_valid = out_vld_reg;
    assign m_reflect_red = out_reg[0];
    assign m_reflect_green = out_reg[1];
    assign m_reflect_blue = out_reg[2];

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reflect_red))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif
endmodule

// ===== dv/conductor_fresnel_reflectance_unit_test.sv =====
module conductor_fresnel_reflectance_unit_test;
    import cfr_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int DrainCycles = 40;
    localparam int HoldCycles = 300;
    localparam logic [IdxW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IdxW-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [CosW-1:0] COS_ONE = 16'd32768;

    typedef struct packed {
        logic [OutW-1:0] red;
        logic [OutW-1:0] green;
        logic [OutW-1:0] blue;
    } rgb_t;

    typedef struct {
        logic [CosW-1:0] cosine;
        bit              known;
        logic [OutW-1:0] value;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [IdxW-1:0] cfg_idx = REG_ETA_RED;
    logic [RegW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CosW-1:0] s_cos_incidence = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [OutW-1:0] m_reflect_red, m_reflect_green, m_reflect_blue;

    logic [RegW-1:0] optics [NumRegs];
    rgb_t pending_rgb [$];
    int errors = 0;
    int cycles = 0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;

    conductor_fresnel_reflectance_unit dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint frac_q16(longint num, longint den);
        if (num < 0) num = 0;
        if (den <= 0) return 0;
        return (num * 65536) / den;
    endfunction

    function automatic logic [OutW-1:0] reflectance(logic [RegW-1:0] eta,
                                                    logic [RegW-1:0] absorb,
                                                    logic [CosW-1:0] c);
        longint t, s, ts, d, m;
        t = (longint'(eta) * eta + longint'(absorb) * absorb) >>> 8;
        s = (longint'(c) * c) >>> 14;
        ts = (t * s) >>> 16;
        d = (longint'(eta) * c) >>> 10;
        m = (frac_q16(ts - d + 65536, ts + d + 65536) + frac_q16(t - d + s, t + d + s)) >>> 1;
        return (m > 65535) ? 16'hFFFF : m[15:0];
    endfunction

    function automatic rgb_t shade(logic [CosW-1:0] c);
        rgb_t r;
        r.red = reflectance(optics[REG_ETA_RED], optics[REG_ABS_RED], c);
        r.green = reflectance(optics[REG_ETA_GREEN], optics[REG_ABS_GREEN], c);
        r.blue = reflectance(optics[REG_ETA_BLUE], optics[REG_ABS_BLUE], c);
        return r;
    endfunction

    // result side: random ready, one long hold-off on request
    initial begin
        int idle_left;
        idle_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HoldCycles) @(negedge aclk);
                hold_done = 1'b1;
            end else if (idle_left > 0) begin
                m_ready <= 1'b0;
                idle_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 4);
                else if ($urandom_range(0, 80) == 0) idle_left = $urandom_range(20, 60);
            end
        end
    end

    always @(posedge aclk) begin
        rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rgb.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                want = pending_rgb.pop_front();
                if (m_reflect_red !== want.red) begin
                    $error("reflect_red exp %0d got %0d", want.red, m_reflect_red);
                    errors++;
                end
                if (m_reflect_green !== want.green) begin
                    $error("reflect_green exp %0d got %0d", want.green, m_reflect_green);
                    errors++;
                end
                if (m_reflect_blue !== want.blue) begin
                    $error("reflect_blue exp %0d got %0d", want.blue, m_reflect_blue);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge aclk);
        if (idx < NumRegs) optics[idx] = value;
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_cos(logic [CosW-1:0] c);
        int gap;
        gap = 0;
        if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
        else if ($urandom_range(0, 60) == 0) gap = $urandom_range(20, 60);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_cos_incidence <= c;
        do @(posedge aclk); while (!s_ready);
        pending_rgb.push_back(shade(c));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    function automatic logic [CosW-1:0] random_cos();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return CosW'($urandom_range(0, 32768));
        if (pick < 9) return CosW'($urandom_range(0, 65535));
        case ($urandom_range(0, 2))
            0: return '0;
            1: return COS_ONE;
            default: return 16'hFFFF;
        endcase
    endfunction

    stim_row_t directed [12] = '{
        '{16'd0, 1'b1, 16'hFFFF},     // grazing incidence: full reflectance
        '{COS_ONE, 1'b1, 16'd0},      // matched index at normal incidence: zero
        '{16'd1, 1'b0, 16'd0},
        '{16'd32767, 1'b0, 16'd0},
        '{16'd32769, 1'b0, 16'd0},    // cosine above one
        '{16'hFFFF, 1'b0, 16'd0},
        '{16'h5555, 1'b0, 16'd0},
        '{16'hAAAA, 1'b0, 16'd0},
        '{16'd16384, 1'b0, 16'd0},
        '{16'd8192, 1'b0, 16'd0},
        '{16'h7FFF, 1'b0, 16'd0},
        '{16'h8001, 1'b0, 16'd0}
    };

    initial begin
        optics[REG_ETA_RED] = 16'd4096;
        optics[REG_ETA_GREEN] = 16'd4096;
        optics[REG_ETA_BLUE] = 16'd4096;
        optics[REG_ABS_RED] = '0;
        optics[REG_ABS_GREEN] = '0;
        optics[REG_ABS_BLUE] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_cos(directed[i].cosine);
            if (directed[i].known) begin
                pending_rgb[$] = '{directed[i].value, directed[i].value, directed[i].value};
            end
        end
        drain();

        // all zero: zero denominator at zero cosine
        for (int r = 0; r < NumRegs; r++) write_reg(IdxW'(r), '0);
        end_writes();
        send_cos('0);
        send_cos(COS_ONE);
        send_cos(16'hFFFF);
        send_cos(16'd1);
        drain();

        // all registers at max, spare indexes must be ignored
        for (int r = 0; r < NumRegs; r++) write_reg(IdxW'(r), 16'hFFFF);
        write_reg(REG_SPARE_LO, 16'h1234);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        end_writes();
        send_cos('0);
        send_cos(COS_ONE);
        send_cos(16'hFFFF);
        send_cos(16'd16384);
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            for (int r = 0; r < NumRegs; r++) begin
                if (phase % 2 == 0) write_reg(IdxW'(r), RegW'($urandom_range(0, 65535)));
                else write_reg(IdxW'(r), (r < 3) ? RegW'($urandom_range(4096, 20480))
                                                 : RegW'($urandom_range(0, 24576)));
            end
            if (phase == 4) write_reg(REG_SPARE_HI, RegW'($urandom_range(0, 65535)));
            end_writes();
            if (phase == 3) hold_request = 1'b1;
            for (int n = 0; n < 107; n++) send_cos(random_cos());
            drain();
        end

        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
